// ===== src/m9rv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the median-of-nine ratiometric voltmeter.
// No dependencies; imported by median9_ratiometric_voltmeter.
package m9rv_pkg;

   // Sample window geometry
   localparam int WINDOW_LEN  = 9;
   localparam int SLOT_W      = $clog2(WINDOW_LEN);
   localparam int SORT_LANES  = (WINDOW_LEN - 1) / 2;
   localparam int MEDIAN_SLOT = (WINDOW_LEN - 1) / 2;

   typedef logic [SLOT_W-1:0] slot_type;

   localparam slot_type LAST_SLOT = slot_type'(WINDOW_LEN - 1);

   // Configuration registers
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_REFRESH_PERIOD = 1'd0;
   localparam csr_index_type CSR_SCALE          = 1'd1;

   localparam logic [CSR_W-1:0] REFRESH_PERIOD_RST = 16'd300;
   localparam logic [CSR_W-1:0] SCALE_RST          = 16'd1800;

   // Output voltage
   localparam int VOLT_W = 15;
   localparam logic [VOLT_W-1:0] VOLT_MAX = 15'h7FFF;

   // Request opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SORT,
      ST_ACCUM,
      ST_DIV_IN,
      ST_DIV_REF,
      ST_MUL,
      ST_DIV_V,
      ST_DONE
   } state_type;

endpackage

// ===== src/median9_ratiometric_voltmeter.sv =====
`timescale 1ns / 1ps
// Median-of-nine ratiometric voltmeter: window sort, channel sums, shared divider.
// Depends on m9rv_pkg.
//
// Usage
//   req_*  : one request per converter sample (req_op = OP_SAMPLE, req_sample)
//            or per millisecond tick (req_op = OP_TICK). req_ready is high only
//            while the sequencer is idle; one request is handled at a time.
//   rsp_*  : exactly one response per request: the held voltage, a flag when
//            the request closed a refresh period, a no-data flag, and the
//            channel to sample next.
//   csr_*  : register writes (index 0 refresh period, index 1 scale in mV),
//            always ready; write only while no request is in flight.
// Work per request (from request accept to the response)
//   plain sample or tick              : decode only
//   sample that completes the window  : 9 odd-even sort passes, then accumulate
//   tick that refreshes with data     : input average, reference average, ratio,
//     one after another on the one-bit-per-cycle restoring divider, shared by
//     the two channel averages and the final ratio; DIV_W is the dividend width.
// Requests do not overlap: the next request is taken in idle, after the response
// register is loaded; a new request waits until the last one is done.
// Reset clears sums, counts, window fill, timer, held voltage and restores
// the register defaults. A stalled rsp_ready holds the response register; the
// block still takes and works one more request, then waits in its final state
// until the held response is taken, and no request is taken meanwhile.
module median9_ratiometric_voltmeter
   import m9rv_pkg::*;
#(
   parameter int SAMPLE_BITS = 10,
   parameter int COUNT_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VOLT_W-1:0]      rsp_voltage_mv,
   output logic                   rsp_reading_done,
   output logic                   rsp_no_data_error,
   output logic                   rsp_next_channel,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  csr_index_type          csr_index,
   input  logic [CSR_W-1:0]       csr_data
);

   localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
   localparam int PROD_W = SAMPLE_BITS + CSR_W;
   localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int DVS_W  = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;
   localparam int DCNT_W = $clog2(DIV_W);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [DCNT_W-1:0]     DIV_LAST  = DCNT_W'(DIV_W - 1);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [CSR_W-1:0]       period_ff;
   logic [CSR_W-1:0]       scale_ff;

   logic                   op_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;

   logic [SAMPLE_BITS-1:0] window_ff [WINDOW_LEN];
   logic [SAMPLE_BITS-1:0] window_sorted [WINDOW_LEN];
   slot_type               fill_ff;
   slot_type               sort_cnt_ff;

   logic                   phase_ff;
   logic [SUM_W-1:0]       in_sum_ff;
   logic [SUM_W-1:0]       ref_sum_ff;
   logic [COUNT_BITS-1:0]  in_count_ff;
   logic [COUNT_BITS-1:0]  ref_count_ff;
   logic [CSR_W-1:0]       elapsed_ff;
   logic [VOLT_W-1:0]      held_ff;
   logic                   done_ff;
   logic                   err_ff;

   // shared restoring divider
   logic [DIV_W-1:0]       quo_ff;
   logic [DVS_W-1:0]       rem_ff;
   logic [DVS_W-1:0]       dvs_ff;
   logic [DCNT_W-1:0]      div_cnt_ff;
   logic [SAMPLE_BITS-1:0] avg_in_ff;
   logic [SAMPLE_BITS-1:0] avg_ref_ff;

   logic                   rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Combinational datapath
   // ---------------------------------------------------------------------
   logic               refresh_hit;
   logic               no_data;
   logic [DVS_W:0]     div_shifted;
   logic [DVS_W+1:0]   div_diff;
   logic               div_fits;
   logic [DVS_W-1:0]   rem_next;
   logic [DIV_W-1:0]   quo_next;
   logic [PROD_W-1:0]  product;
   logic [SAMPLE_BITS-1:0] median;

   assign refresh_hit = (op_ff == OP_TICK) && (elapsed_ff >= period_ff);
   assign no_data     = (in_count_ff == '0) || (ref_count_ff == '0);

   // One quotient bit per cycle: shift in the next dividend bit, try to subtract.
   assign div_shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign div_diff    = {1'b0, div_shifted} - {2'b00, dvs_ff};
   assign div_fits    = !div_diff[DVS_W+1];
   assign rem_next    = div_fits ? div_diff[DVS_W-1:0] : div_shifted[DVS_W-1:0];
   assign quo_next    = {quo_ff[DIV_W-2:0], div_fits};

   assign product = PROD_W'(avg_in_ff) * PROD_W'(scale_ff);
   assign median  = window_ff[MEDIAN_SLOT];

   // One odd-even transposition pass; nine passes fully order the window.
   always_comb begin
      window_sorted = window_ff;
      for (int k = 0; k < SORT_LANES; k++) begin
         if (!sort_cnt_ff[0]) begin
            if (window_ff[2*k] > window_ff[2*k+1]) begin
               window_sorted[2*k]   = window_ff[2*k+1];
               window_sorted[2*k+1] = window_ff[2*k];
            end
         end else begin
            if (window_ff[2*k+1] > window_ff[2*k+2]) begin
               window_sorted[2*k+1] = window_ff[2*k+2];
               window_sorted[2*k+2] = window_ff[2*k+1];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   logic div_last;
   logic rsp_load;
   logic period_end;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            priority if (op_ff == OP_SAMPLE) begin
               state_in = (fill_ff == LAST_SLOT) ? ST_SORT : ST_DONE;
            end else if (!refresh_hit || no_data) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV_IN;
            end
         end
         ST_SORT: begin
            if (sort_cnt_ff == LAST_SLOT) state_in = ST_ACCUM;
         end
         ST_ACCUM:   state_in = ST_DONE;
         ST_DIV_IN: begin
            if (div_last) state_in = ST_DIV_REF;
         end
         ST_DIV_REF: begin
            if (div_last) state_in = ST_MUL;
         end
         ST_MUL:     state_in = (avg_ref_ff == '0) ? ST_DONE : ST_DIV_V;
         ST_DIV_V: begin
            if (div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: control outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      div_last   = (div_cnt_ff == DIV_LAST);
      period_end = ((state_ff == ST_DECODE) && refresh_hit && no_data)
                || ((state_ff == ST_MUL) && (avg_ref_ff == '0))
                || ((state_ff == ST_DIV_V) && div_last);
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= REFRESH_PERIOD_RST;
         scale_ff  <= SCALE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_REFRESH_PERIOD: period_ff <= csr_data;
            CSR_SCALE:          scale_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request capture and sample window
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff     <= req_op;
         sample_ff <= req_sample;
      end
      // store the sample at the fill slot, then sort in place when full
      if ((state_ff == ST_DECODE) && (op_ff == OP_SAMPLE)) begin
         window_ff[fill_ff] <= sample_ff;
      end else if (state_ff == ST_SORT) begin
         window_ff <= window_sorted;
      end
      if (state_ff == ST_DECODE) begin
         sort_cnt_ff <= '0;
      end else if (state_ff == ST_SORT) begin
         sort_cnt_ff <= sort_cnt_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Channel accumulation, timer and held reading
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         phase_ff     <= 1'b0;
         in_sum_ff    <= '0;
         ref_sum_ff   <= '0;
         in_count_ff  <= '0;
         ref_count_ff <= '0;
         elapsed_ff   <= '0;
         held_ff      <= '0;
         done_ff      <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         if (state_ff == ST_DECODE) begin
            done_ff <= 1'b0;
            err_ff  <= 1'b0;
            if (op_ff == OP_SAMPLE) begin
               if (fill_ff != LAST_SLOT) fill_ff <= fill_ff + 1'b1;
            end else if (refresh_hit) begin
               elapsed_ff <= '0;
               done_ff    <= 1'b1;
               err_ff     <= no_data;
               if (no_data) held_ff <= '0;
            end else begin
               elapsed_ff <= elapsed_ff + 1'b1;
            end
         end
         // add the median to the active channel; drop it once the count is full
         if (state_ff == ST_ACCUM) begin
            if (phase_ff) begin
               if (ref_count_ff != COUNT_MAX) begin
                  ref_sum_ff   <= ref_sum_ff + SUM_W'(median);
                  ref_count_ff <= ref_count_ff + 1'b1;
               end
            end else begin
               if (in_count_ff != COUNT_MAX) begin
                  in_sum_ff   <= in_sum_ff + SUM_W'(median);
                  in_count_ff <= in_count_ff + 1'b1;
               end
            end
            phase_ff <= !phase_ff;
            fill_ff  <= '0;
         end
         // zero reference average saturates the reading
         if ((state_ff == ST_MUL) && (avg_ref_ff == '0)) begin
            held_ff <= VOLT_MAX;
         end
         if ((state_ff == ST_DIV_V) && div_last) begin
            held_ff <= (|quo_next[DIV_W-1:VOLT_W]) ? VOLT_MAX : quo_next[VOLT_W-1:0];
         end
         if (period_end) begin
            in_sum_ff    <= '0;
            ref_sum_ff   <= '0;
            in_count_ff  <= '0;
            ref_count_ff <= '0;
            fill_ff      <= '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Shared divider: input average, reference average, then the ratio
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      priority if ((state_ff == ST_DECODE) && refresh_hit && !no_data) begin
         quo_ff     <= DIV_W'(in_sum_ff);
         dvs_ff     <= DVS_W'(in_count_ff);
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if ((state_ff == ST_DIV_IN) && div_last) begin
         avg_in_ff  <= quo_next[SAMPLE_BITS-1:0];
         quo_ff     <= DIV_W'(ref_sum_ff);
         dvs_ff     <= DVS_W'(ref_count_ff);
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if ((state_ff == ST_DIV_REF) && div_last) begin
         avg_ref_ff <= quo_next[SAMPLE_BITS-1:0];
      end else if (state_ff == ST_MUL) begin
         quo_ff     <= DIV_W'(product);
         dvs_ff     <= DVS_W'(avg_ref_ff);
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if ((state_ff == ST_DIV_IN) || (state_ff == ST_DIV_REF)
                || (state_ff == ST_DIV_V)) begin
         quo_ff     <= quo_next;
         rem_ff     <= rem_next;
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Response register: hold until taken
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_voltage_mv    <= held_ff;
         rsp_reading_done  <= done_ff;
         rsp_no_data_error <= err_ff;
         rsp_next_channel  <= phase_ff;
      end
   end

endmodule

// ===== tb/tb_median9_ratiometric_voltmeter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for median9_ratiometric_voltmeter: directed request table,
// random sample/tick traffic and a run of ticks at the full-range refresh period.
// Depends on m9rv_pkg and the median9_ratiometric_voltmeter RTL.
module tb_median9_ratiometric_voltmeter;
   import m9rv_pkg::*;

   localparam int SAMPLE_BITS = 10;
   // Narrow counter width for the block under test.
   localparam int COUNT_BITS = 8;
   localparam int unsigned COUNT_FULL = (1 << COUNT_BITS) - 1;
   localparam int HALF_PERIOD = 4;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int unsigned REPORT_CAP = 40;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_REQUESTS = 200;
   localparam int FULL_RANGE_TICKS = 64;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic [VOLT_W-1:0] voltage_mv;
      logic              reading_done;
      logic              no_data_error;
      logic              next_channel;
   } reading_type;

   typedef struct packed {
      logic        op;
      sample_type  sample;
      logic        typed;
      reading_type reading;
   } script_row_type;

   typedef enum logic [1:0] {
      RSP_OPEN,     // always ready
      RSP_COIN,     // ready half the time
      RSP_CHOKED,   // ready with a chance of one in four
      RSP_PULSED    // ready and stalled in alternating equal stretches
   } back_pressure_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_op = OP_SAMPLE;
   sample_type          req_sample = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VOLT_W-1:0]   rsp_voltage_mv;
   logic                rsp_reading_done;
   logic                rsp_no_data_error;
   logic                rsp_next_channel;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_REFRESH_PERIOD;
   logic [CSR_W-1:0]    csr_data = '0;

   median9_ratiometric_voltmeter #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_voltage_mv   (rsp_voltage_mv),
      .rsp_reading_done (rsp_reading_done),
      .rsp_no_data_error(rsp_no_data_error),
      .rsp_next_channel (rsp_next_channel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------------
   // Meter predictor: own copy of registers and accumulator state.
   // ---------------------------------------------------------------------------
   logic [CSR_W-1:0]  period_ms = REFRESH_PERIOD_RST;
   logic [CSR_W-1:0]  scale = SCALE_RST;
   sample_type        window [WINDOW_LEN];
   int unsigned       fill = 0;
   logic              on_reference = 1'b0;
   longint unsigned   in_sum = 0;
   longint unsigned   ref_sum = 0;
   int unsigned       in_count = 0;
   int unsigned       ref_count = 0;
   int unsigned       elapsed_ms = 0;
   logic [VOLT_W-1:0] held_mv = '0;

   // Median by plain insertion sort; independent of the compare-exchange network.
   function automatic sample_type window_median();
      sample_type w [WINDOW_LEN];
      sample_type t;
      int j;
      w = window;
      for (int i = 1; i < WINDOW_LEN; i++) begin
         t = w[i];
         j = i;
         while (j > 0 && w[j-1] > t) begin
            w[j] = w[j-1];
            j--;
         end
         w[j] = t;
      end
      return w[WINDOW_LEN/2];
   endfunction

   // With data on both channels, average them and form the ratio; clear the period; return the no-data flag.
   function automatic logic close_period();
      longint unsigned avg_in, avg_ref, volts;
      logic starved;
      starved = (in_count == 0 || ref_count == 0);
      if (starved) begin
         held_mv = '0;
      end else begin
         avg_in = in_sum / in_count;
         avg_ref = ref_sum / ref_count;
         // A reference average that truncates to zero pins the output at full scale.
         volts = (avg_ref == 0) ? longint'(VOLT_MAX) : avg_in * scale / avg_ref;
         held_mv = (volts > VOLT_MAX) ? VOLT_MAX : volts[VOLT_W-1:0];
      end
      in_sum = 0;
      ref_sum = 0;
      in_count = 0;
      ref_count = 0;
      fill = 0;
      return starved;
   endfunction

   function automatic reading_type meter_step(logic op, sample_type smp);
      reading_type r;
      sample_type mid;
      r = '0;
      if (op == OP_SAMPLE) begin
         window[fill] = smp;
         if (fill == WINDOW_LEN - 1) begin
            mid = window_median();
            // Drop the median once its channel count is full; the channel still toggles.
            if (on_reference) begin
               if (ref_count < COUNT_FULL) begin
                  ref_sum += mid;
                  ref_count++;
               end
            end else if (in_count < COUNT_FULL) begin
               in_sum += mid;
               in_count++;
            end
            on_reference = !on_reference;
            fill = 0;
         end else begin
            fill++;
         end
      end else if (elapsed_ms >= period_ms) begin
         elapsed_ms = 0;
         r.reading_done = 1'b1;
         r.no_data_error = close_period();
      end else begin
         elapsed_ms++;
      end
      r.voltage_mv = held_mv;
      r.next_channel = on_reference;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------------
   reading_type expected_readings [$];
   int unsigned mismatches = 0;
   int unsigned responses_seen = 0;

   task automatic report_mismatch(string what);
      if (mismatches < REPORT_CAP)
         $display("[%0t] response %0d: %s", $time, responses_seen, what);
      mismatches++;
   endtask

   // Sample at the rising edge; compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = expected_readings.pop_front();
            if (rsp_voltage_mv !== want.voltage_mv)
               report_mismatch($sformatf("voltage_mv %0d, expected %0d",
                                         rsp_voltage_mv, want.voltage_mv));
            if (rsp_reading_done !== want.reading_done)
               report_mismatch($sformatf("reading_done %b, expected %b",
                                         rsp_reading_done, want.reading_done));
            if (rsp_no_data_error !== want.no_data_error)
               report_mismatch($sformatf("no_data_error %b, expected %b",
                                         rsp_no_data_error, want.no_data_error));
            if (rsp_next_channel !== want.next_channel)
               report_mismatch($sformatf("next_channel %b, expected %b",
                                         rsp_next_channel, want.next_channel));
         end
         responses_seen++;
      end
   end

   // Bound the run; a hung handshake ends here.
   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Response back-pressure: switch between stall patterns every stretch.
   // ---------------------------------------------------------------------------
   back_pressure_type pressure = RSP_OPEN;
   int unsigned pressure_left = 0;

   always @(negedge clock) begin
      if (pressure_left == 0) begin
         pressure = back_pressure_type'($urandom_range(0, 3));
         pressure_left = $urandom_range(10, 150);
      end
      pressure_left--;
      case (pressure)
         RSP_OPEN:   rsp_ready <= 1'b1;
         RSP_COIN:   rsp_ready <= ($urandom_range(0, 1) == 0);
         RSP_CHOKED: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:    rsp_ready <= pressure_left[2];
      endcase
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   int unsigned burst_left = 0;

   // Present one request at the current falling edge, hold it until accepted, predict,
   // then either keep valid up for the next request of the burst or drop it for a gap.
   task automatic send_request(logic op, sample_type smp, logic typed,
                               reading_type typed_reading);
      reading_type predicted;
      req_valid <= 1'b1;
      req_op <= op;
      req_sample <= smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = meter_step(op, smp);
      expected_readings.push_back(typed ? typed_reading : predicted);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         // Mostly short bursts; now and then a long stretch without gaps.
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(0, 20);
      end
   endtask

   // Call at a falling edge: drop valid so no stale request is taken again.
   task automatic hold_requests();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_readings.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write both registers back to back; valid stays high across the two writes.
   task automatic configure(logic [CSR_W-1:0] period, logic [CSR_W-1:0] mv);
      csr_valid <= 1'b1;
      csr_index <= CSR_REFRESH_PERIOD;
      csr_data <= period;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      period_ms = period;
      @(negedge clock);
      csr_index <= CSR_SCALE;
      csr_data <= mv;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      scale = mv;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Signal levels for the random samples of each channel.
   int in_level = 512;
   int ref_level = 800;
   int spread = 16;

   function automatic sample_type draw_sample(logic for_reference);
      int level, v;
      level = for_reference ? ref_level : in_level;
      case ($urandom_range(0, 9))
         0: return ($urandom_range(0, 1) == 1) ? '1 : '0;   // rail hit
         1, 2: return sample_type'($urandom);              // glitch anywhere in range
         default: begin
            v = level + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0) v = 0;
            if (v > (1 << SAMPLE_BITS) - 1) v = (1 << SAMPLE_BITS) - 1;
            return sample_type'(v);
         end
      endcase
   endfunction

   function automatic script_row_type step_row(logic op, sample_type smp,
                                               logic [VOLT_W-1:0] mv, logic done,
                                               logic starved, logic chan);
      script_row_type row;
      row.op = op;
      row.sample = smp;
      row.typed = 1'b1;
      row.reading = '{voltage_mv: mv, reading_done: done, no_data_error: starved,
                      next_channel: chan};
      return row;
   endfunction

   script_row_type directed_rows [23];

   task automatic run_rows(int first, int last);
      for (int i = first; i <= last; i++)
         send_request(directed_rows[i].op, directed_rows[i].sample, directed_rows[i].typed,
                      directed_rows[i].reading);
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [CSR_W-1:0] period, mv;
      directed_rows = '{
         // reset defaults: tick only advances the timer, sample only fills the window
         step_row(OP_TICK,   10'd0,    15'd0,     1'b0, 1'b0, 1'b0),
         step_row(OP_SAMPLE, 10'd1023, 15'd0,     1'b0, 1'b0, 1'b0),
         // period 0: every tick refreshes; nothing collected yet
         step_row(OP_TICK,   10'd0,    15'd0,     1'b1, 1'b1, 1'b0),
         // measured-input window with both rails, closes on the ninth sample
         step_row(OP_SAMPLE, 10'd1023, 15'd0,     1'b0, 1'b0, 1'b0),
         step_row(OP_SAMPLE, 10'd0,    15'd0,     1'b0, 1'b0, 1'b0),
         step_row(OP_SAMPLE, 10'd512,  15'd0,     1'b0, 1'b0, 1'b0),
         step_row(OP_SAMPLE, 10'd1,    15'd0,     1'b0, 1'b0, 1'b0),
         step_row(OP_SAMPLE, 10'd1022, 15'd0,     1'b0, 1'b0, 1'b0),
         step_row(OP_SAMPLE, 10'd300,  15'd0,     1'b0, 1'b0, 1'b0),
         step_row(OP_SAMPLE, 10'd700,  15'd0,     1'b0, 1'b0, 1'b0),
         step_row(OP_SAMPLE, 10'd511,  15'd0,     1'b0, 1'b0, 1'b0),
         step_row(OP_SAMPLE, 10'd1023, 15'd0,     1'b0, 1'b0, 1'b1),
         // all-zero reference window
         step_row(OP_SAMPLE, 10'd0,    15'd0,     1'b0, 1'b0, 1'b1),
         step_row(OP_SAMPLE, 10'd0,    15'd0,     1'b0, 1'b0, 1'b1),
         step_row(OP_SAMPLE, 10'd0,    15'd0,     1'b0, 1'b0, 1'b1),
         step_row(OP_SAMPLE, 10'd0,    15'd0,     1'b0, 1'b0, 1'b1),
         step_row(OP_SAMPLE, 10'd0,    15'd0,     1'b0, 1'b0, 1'b1),
         step_row(OP_SAMPLE, 10'd0,    15'd0,     1'b0, 1'b0, 1'b1),
         step_row(OP_SAMPLE, 10'd0,    15'd0,     1'b0, 1'b0, 1'b1),
         step_row(OP_SAMPLE, 10'd0,    15'd0,     1'b0, 1'b0, 1'b1),
         step_row(OP_SAMPLE, 10'd0,    15'd0,     1'b0, 1'b0, 1'b0),
         // zero reference average saturates; the next refresh finds no data
         step_row(OP_TICK,   10'd0,    VOLT_MAX,  1'b1, 1'b0, 1'b0),
         step_row(OP_TICK,   10'd1023, 15'd0,     1'b1, 1'b1, 1'b0)
      };

      // Hold reset, then release it at a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: two requests at reset defaults, the rest with period 0.
      run_rows(0, 1);
      hold_requests();
      wait_drained();
      configure(16'd0, SCALE_RST);
      run_rows(2, 22);

      // Random phases: a new register setting and new channel levels each time.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       begin period = 16'd0; mv = 16'hFFFF; end
            1:       begin period = 16'd1; mv = 16'd1; end
            2:       begin period = 16'd3; mv = SCALE_RST; end
            default: begin
               period = CSR_W'($urandom_range(0, 8));
               mv = CSR_W'($urandom_range(1, 16'hFFFF));
            end
         endcase
         in_level = $urandom_range(0, 1023);
         ref_level = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 1023);
         spread = $urandom_range(0, 64);
         hold_requests();
         wait_drained();
         configure(period, mv);
         repeat (PHASE_REQUESTS) begin
            if ($urandom_range(1, 8) == 1)
               send_request(OP_TICK, sample_type'($urandom), 1'b0, '0);
            else
               send_request(OP_SAMPLE, draw_sample(on_reference), 1'b0, '0);
         end
      end

      // Full-range period: a run of ticks that stays short of the refresh.
      hold_requests();
      wait_drained();
      configure(16'hFFFF, SCALE_RST);
      in_level = $urandom_range(100, 900);
      ref_level = $urandom_range(100, 900);
      repeat (4 * WINDOW_LEN) send_request(OP_SAMPLE, draw_sample(on_reference), 1'b0, '0);
      repeat (FULL_RANGE_TICKS) send_request(OP_TICK, sample_type'($urandom), 1'b0, '0);

      // Drain and let the block settle past its longest refresh latency.
      hold_requests();
      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_readings.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
